// ===== rtl/core/das_pkg.sv =====
// das_pkg: shared types and constants for the direction/sector core.
// Holds the CORDIC datapath widths, the arctangent table and the cell payload struct.
// No dependencies.
package das_pkg;

    localparam int DAS_IN_W    = 16;
    localparam int DAS_DIFF_W  = DAS_IN_W + 1;
    localparam int DAS_PRESHIFT = 14;
    localparam int DAS_W       = 34;
    localparam int DAS_ZW      = 20;
    localparam int DAS_DIR_W   = 16;
    localparam int DAS_SEC_W   = 4;
    localparam int DAS_STEPS   = 16;
    localparam int DAS_SECTORS_DEF = 12;

    localparam logic [DAS_ZW-1:0] DAS_HALF_TURN = 20'h80000;
    localparam logic [DAS_ZW-1:0] DAS_ROUND     = 20'd8;

    localparam logic [DAS_ZW-1:0] DAS_ATAB [DAS_STEPS] = '{
        20'd131072, 20'd77376, 20'd40883, 20'd20753,
        20'd10417,  20'd5213,  20'd2607,  20'd1304,
        20'd652,    20'd326,   20'd163,   20'd81,
        20'd41,     20'd20,    20'd10,    20'd5
    };

    typedef struct packed {
        logic signed [DAS_W-1:0] x;
        logic signed [DAS_W-1:0] y;
        logic [DAS_ZW-1:0]       z;
        logic                    coin;
    } t_vec;

endpackage

// ===== rtl/core/das_prep.sv =====
// das_prep: entry cell; forms the offset vector, folds it into the right half-plane.
// Depends on das_pkg.
module das_prep (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic signed [das_pkg::DAS_IN_W-1:0]  i_from_x,
    input  logic signed [das_pkg::DAS_IN_W-1:0]  i_from_y,
    input  logic signed [das_pkg::DAS_IN_W-1:0]  i_to_x,
    input  logic signed [das_pkg::DAS_IN_W-1:0]  i_to_y,
    input  logic                                 i_ready,
    output logic                                 o_valid,
    output das_pkg::t_vec                        o_data
);

    logic signed [das_pkg::DAS_DIFF_W-1:0] dx;
    logic signed [das_pkg::DAS_DIFF_W-1:0] dy;
    logic signed [das_pkg::DAS_W-1:0]      xw;
    logic signed [das_pkg::DAS_W-1:0]      yw;
    das_pkg::t_vec                          n_data;
    das_pkg::t_vec                          r_data;
    logic                                   r_valid;

    always_comb begin
        dx = das_pkg::DAS_DIFF_W'(i_to_x) - das_pkg::DAS_DIFF_W'(i_from_x);
        dy = das_pkg::DAS_DIFF_W'(i_to_y) - das_pkg::DAS_DIFF_W'(i_from_y);
        xw = das_pkg::DAS_W'(dx) <<< das_pkg::DAS_PRESHIFT;
        yw = das_pkg::DAS_W'(dy) <<< das_pkg::DAS_PRESHIFT;
        n_data.coin = (dx == '0) && (dy == '0);
        if (dx[das_pkg::DAS_DIFF_W-1]) begin
            n_data.x = -xw;
            n_data.y = -yw;
            n_data.z = das_pkg::DAS_HALF_TURN;
        end else begin
            n_data.x = xw;
            n_data.y = yw;
            n_data.z = '0;
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== rtl/core/das_cell.sv =====
// das_cell: one CORDIC vectoring micro-rotation with its pipeline register.
// Depends on das_pkg.
module das_cell #(
    parameter int STEP = 0
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  das_pkg::t_vec i_data,
    input  logic          i_ready,
    output logic          o_valid,
    output das_pkg::t_vec o_data
);

    logic signed [das_pkg::DAS_W-1:0] x_in;
    logic signed [das_pkg::DAS_W-1:0] y_in;
    logic signed [das_pkg::DAS_W-1:0] xs;
    logic signed [das_pkg::DAS_W-1:0] ys;
    das_pkg::t_vec                     n_data;
    das_pkg::t_vec                     r_data;
    logic                              r_valid;

    always_comb begin
        x_in = i_data.x;
        y_in = i_data.y;
        xs   = x_in >>> STEP;
        ys   = y_in >>> STEP;
        n_data.coin = i_data.coin;
        if (!y_in[das_pkg::DAS_W-1]) begin
            n_data.x = x_in + ys;
            n_data.y = y_in - xs;
            n_data.z = i_data.z + das_pkg::DAS_ATAB[STEP];
        end else begin
            n_data.x = x_in - ys;
            n_data.y = y_in + xs;
            n_data.z = i_data.z - das_pkg::DAS_ATAB[STEP];
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== rtl/core/das_out.sv =====
// das_out: exit cell; rounds the angle to 16 bits and maps it to a sector.
// Depends on das_pkg.
module das_out #(
    parameter int SECTORS = das_pkg::DAS_SECTORS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  das_pkg::t_vec                     i_data,
    input  logic                              i_ready,
    output logic                              o_valid,
    output logic [das_pkg::DAS_DIR_W-1:0]     o_direction,
    output logic [das_pkg::DAS_SEC_W-1:0]     o_sector,
    output logic                              o_coincident
);

    localparam int SW = $clog2(SECTORS + 1);
    localparam int PW = das_pkg::DAS_DIR_W + SW;
    localparam logic [SW-1:0] SEC_K = SW'(SECTORS);

    logic [das_pkg::DAS_ZW-1:0]  zr;
    logic [das_pkg::DAS_DIR_W-1:0] dir;
    logic [PW-1:0]               prod;
    logic [PW-1:0]               prod_sh;
    logic [das_pkg::DAS_DIR_W-1:0] n_dir;
    logic [das_pkg::DAS_SEC_W-1:0] n_sec;
    logic [das_pkg::DAS_DIR_W-1:0] r_dir;
    logic [das_pkg::DAS_SEC_W-1:0] r_sec;
    logic                          r_coin;
    logic                          r_valid;

    always_comb begin
        zr      = i_data.z + das_pkg::DAS_ROUND;
        dir     = zr[das_pkg::DAS_ZW-1 -: das_pkg::DAS_DIR_W];
        prod    = PW'(dir) * PW'(SEC_K);
        prod_sh = prod >> das_pkg::DAS_DIR_W;
        n_dir   = i_data.coin ? '0 : dir;
        n_sec   = i_data.coin ? '0 : prod_sh[das_pkg::DAS_SEC_W-1:0];
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_dir  <= n_dir;
            r_sec  <= n_sec;
            r_coin <= i_data.coin;
        end
    end

    assign o_valid      = r_valid;
    assign o_direction  = r_dir;
    assign o_sector     = r_sec;
    assign o_coincident = r_coin;

endmodule

// ===== rtl/core/direction_angle_sector_core.sv =====
// direction_angle_sector_core: direction and angular sector between two 2-D points.
// Depends on das_pkg, das_prep, das_cell, das_out.
//
// Takes one request (two signed 16-bit points) per clock while o_stall is low and
// returns the angle of the vector from the first to the second point as a 16-bit
// fraction of a turn, the index of the one of SECTORS equal sectors that holds it,
// and a flag for coincident points. The path is one entry cell, a chain of 16 CORDIC
// vectoring cells and one rounding/sector cell, each registered. Throughput is one
// request per cycle while o_stall is low; stall propagates back through the chain cell by
// cell, so empty cells still take data while a result waits at the output.
module direction_angle_sector_core #(
    parameter int SECTORS = das_pkg::DAS_SECTORS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic signed [das_pkg::DAS_IN_W-1:0]  i_from_x,
    input  logic signed [das_pkg::DAS_IN_W-1:0]  i_from_y,
    input  logic signed [das_pkg::DAS_IN_W-1:0]  i_to_x,
    input  logic signed [das_pkg::DAS_IN_W-1:0]  i_to_y,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic [das_pkg::DAS_DIR_W-1:0]        o_direction,
    output logic [das_pkg::DAS_SEC_W-1:0]        o_sector,
    output logic                                 o_coincident
);

    localparam int N = das_pkg::DAS_STEPS;

    das_pkg::t_vec chain_d [N+1];
    logic          chain_v [N+1];
    logic          chain_r [N+2];

    das_prep u_prep (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (chain_r[0]),
        .i_from_x (i_from_x),
        .i_from_y (i_from_y),
        .i_to_x   (i_to_x),
        .i_to_y   (i_to_y),
        .i_ready  (chain_r[1]),
        .o_valid  (chain_v[0]),
        .o_data   (chain_d[0])
    );

    for (genvar g = 0; g < N; g++) begin : g_cell
        das_cell #(
            .STEP (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (chain_v[g]),
            .o_ready (chain_r[g+1]),
            .i_data  (chain_d[g]),
            .i_ready (chain_r[g+2]),
            .o_valid (chain_v[g+1]),
            .o_data  (chain_d[g+1])
        );
    end

    das_out #(
        .SECTORS (SECTORS)
    ) u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (chain_v[N]),
        .o_ready      (chain_r[N+1]),
        .i_data       (chain_d[N]),
        .i_ready      (!i_stall),
        .o_valid      (o_valid),
        .o_direction  (o_direction),
        .o_sector     (o_sector),
        .o_coincident (o_coincident)
    );

    assign o_stall = !chain_r[0];

    // coincident points always come out as angle and sector zero
    a_coin_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_coincident |-> o_direction == '0 && o_sector == '0)
        else $error("coincident request with non-zero angle or sector");

    a_sector_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> 32'(o_sector) < SECTORS || SECTORS > 16)
        else $error("sector index out of range");

    // an empty or draining output cell frees the whole chain
    a_no_stall_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled while output cell is empty");

    a_no_stall_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_stall |-> !o_stall)
        else $error("input stalled while output drains");

endmodule

// ===== tb/direction_angle_sector_core_tb.sv =====
`timescale 1ns / 100ps
// direction_angle_sector_core_tb: self-checking bench for the direction/sector core.
// Predicts the direction, sector and coincident flag of each request and compares
// them in order against the outputs. Depends on das_pkg and direction_angle_sector_core.
module direction_angle_sector_core_tb;

    localparam int SECTOR_COUNT = das_pkg::DAS_SECTORS_DEF;
    localparam int IN_W = das_pkg::DAS_IN_W;
    localparam int PHASE_REQUESTS = 200;

    typedef logic signed [IN_W-1:0] coord_t;

    typedef struct packed {
        logic [das_pkg::DAS_DIR_W-1:0] direction;
        logic [das_pkg::DAS_SEC_W-1:0] sector;
        logic                          coincident;
    } dir_result_t;

    class direction_scoreboard;
        dir_result_t pending_dirs[$];
        logic [19:0] atan_steps[16];
        int          sectors;
        int          errors;
        int          checked;
        int          coincident_seen;

        function new(int sector_count);
            sectors = sector_count;
            atan_steps = '{20'd131072, 20'd77376, 20'd40883, 20'd20753,
                           20'd10417,  20'd5213,  20'd2607,  20'd1304,
                           20'd652,    20'd326,   20'd163,   20'd81,
                           20'd41,     20'd20,    20'd10,    20'd5};
            errors = 0;
            checked = 0;
            coincident_seen = 0;
        endfunction

        function dir_result_t predict_direction(coord_t fx, coord_t fy, coord_t tx, coord_t ty);
            logic signed [IN_W:0] dx;
            logic signed [IN_W:0] dy;
            longint      x;
            longint      y;
            longint      xs;
            longint      ys;
            logic [19:0] z;
            logic [20:0] z_rnd;
            logic [31:0] prod;
            dir_result_t r;
            dx = {tx[IN_W-1], tx} - {fx[IN_W-1], fx};
            dy = {ty[IN_W-1], ty} - {fy[IN_W-1], fy};
            if (dx == 0 && dy == 0) begin
                r.direction = '0;
                r.sector = '0;
                r.coincident = 1'b1;
                return r;
            end
            x = longint'(dx) * 16384;
            y = longint'(dy) * 16384;
            z = '0;
            if (dx < 0) begin
                x = -x;
                y = -y;
                z = 20'h80000;
            end
            for (int i = 0; i < 16; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (y >= 0) begin
                    x = x + ys;
                    y = y - xs;
                    z = z + atan_steps[i];
                end else begin
                    x = x - ys;
                    y = y + xs;
                    z = z - atan_steps[i];
                end
            end
            // round half up; a value just short of a full turn wraps to zero
            z_rnd = {1'b0, z} + 21'd8;
            r.direction = z_rnd[19:4];
            prod = 32'(r.direction) * 32'(sectors);
            r.sector = prod[19:16];
            r.coincident = 1'b0;
            return r;
        endfunction

        function void note_request(coord_t fx, coord_t fy, coord_t tx, coord_t ty);
            pending_dirs.push_back(predict_direction(fx, fy, tx, ty));
        endfunction

        task report(string what, int unsigned want, int unsigned got);
            $display("mismatch at %0t: %s expected %0d got %0d", $time, what, want, got);
            errors++;
        endtask

        task check_result(logic [das_pkg::DAS_DIR_W-1:0] direction,
                          logic [das_pkg::DAS_SEC_W-1:0] sector, logic coincident);
            dir_result_t want;
            if (pending_dirs.size() == 0) begin
                report("unexpected result, direction", 0, direction);
                return;
            end
            want = pending_dirs.pop_front();
            checked++;
            if (want.coincident)
                coincident_seen++;
            if (direction !== want.direction)
                report("direction", want.direction, direction);
            if (sector !== want.sector)
                report("sector", want.sector, sector);
            if (coincident !== want.coincident)
                report("coincident", want.coincident, coincident);
        endtask
    endclass

    logic   i_clk = 1'b0;
    logic   i_rst_n = 1'b0;
    logic   i_valid = 1'b0;
    logic   i_stall = 1'b0;
    coord_t i_from_x = '0;
    coord_t i_from_y = '0;
    coord_t i_to_x = '0;
    coord_t i_to_y = '0;
    logic   o_stall;
    logic   o_valid;
    logic [das_pkg::DAS_DIR_W-1:0] o_direction;
    logic [das_pkg::DAS_SEC_W-1:0] o_sector;
    logic   o_coincident;

    int sender_idle_pct = 0;
    int recv_stall_pct = 0;
    int requests_sent = 0;
    direction_scoreboard board;

    direction_angle_sector_core #(
        .SECTORS(SECTOR_COUNT)
    ) u_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_from_x(i_from_x),
        .i_from_y(i_from_y),
        .i_to_x(i_to_x),
        .i_to_y(i_to_y),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_direction(o_direction),
        .o_sector(o_sector),
        .o_coincident(o_coincident)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("[direction_angle_sector_core] ERROR");
        $finish;
    end

    // result side: sample at the rising edge, move stall at the falling edge
    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid === 1'b1 && !i_stall)
                board.check_result(o_direction, o_sector, o_coincident);
            @(negedge i_clk);
            i_stall = ($urandom_range(99) < recv_stall_pct);
        end
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_pair(coord_t fx, coord_t fy, coord_t tx, coord_t ty);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_from_x = fx;
        i_from_y = fy;
        i_to_x = tx;
        i_to_y = ty;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        board.note_request(fx, fy, tx, ty);
        requests_sent++;
        @(negedge i_clk);
    endtask

    task automatic random_pair(output coord_t fx, output coord_t fy,
                               output coord_t tx, output coord_t ty);
        int kind;
        kind = $urandom_range(99);
        fx = coord_t'($urandom);
        fy = coord_t'($urandom);
        tx = coord_t'($urandom);
        ty = coord_t'($urandom);
        if (kind < 60) begin
            return;
        end else if (kind < 75) begin
            tx = fx + coord_t'($urandom_range(8)) - coord_t'(4);
            ty = fy + coord_t'($urandom_range(8)) - coord_t'(4);
        end else if (kind < 85) begin
            tx = fx;
            ty = fy;
        end else if (kind < 95) begin
            if (kind[0])
                tx = fx;
            else
                ty = fy;
        end else begin
            fx = $urandom_range(1) ? coord_t'(16'h8000) : coord_t'(16'h7fff);
            tx = $urandom_range(1) ? coord_t'(16'h8000) : coord_t'(16'h7fff);
            ty = fy + coord_t'($urandom_range(2)) - coord_t'(1);
        end
    endtask

    initial begin
        coord_t fx;
        coord_t fy;
        coord_t tx;
        coord_t ty;
        int sender_pcts[4];
        int recv_pcts[4];
        sender_pcts = '{0, 79, 0, 31};
        recv_pcts = '{0, 0, 79, 31};
        board = new(SECTOR_COUNT);
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // coincident points, extreme offsets, axes, diagonals, wrap near a full turn
        send_pair(0, 0, 0, 0);
        send_pair(-32768, -32768, -32768, -32768);
        send_pair(32767, 32767, 32767, 32767);
        send_pair(-32768, 0, 32767, 0);
        send_pair(32767, 0, -32768, 0);
        send_pair(0, -32768, 0, 32767);
        send_pair(0, 32767, 0, -32768);
        send_pair(0, 0, 1, 0);
        send_pair(0, 0, -1, 0);
        send_pair(0, 0, 0, 1);
        send_pair(0, 0, 0, -1);
        send_pair(0, 0, 1, 1);
        send_pair(0, 0, -1, 1);
        send_pair(0, 0, -1, -1);
        send_pair(0, 0, 1, -1);
        send_pair(-32768, 32767, 32767, 32766);
        send_pair(0, 0, 32767, -1);
        send_pair(-32768, -32768, 32767, 32767);
        send_pair(32767, 32767, -32768, -32768);
        send_pair(0, 0, -32768, -1);
        send_pair(0, 0, -32768, 1);
        send_pair(100, -200, -300, 400);
        send_pair(-1, -1, 0, 0);

        for (int phase = 0; phase < 4; phase++) begin
            sender_idle_pct = sender_pcts[phase];
            recv_stall_pct = recv_pcts[phase];
            repeat (PHASE_REQUESTS) begin
                random_pair(fx, fy, tx, ty);
                send_pair(fx, fy, tx, ty);
            end
        end
        i_valid = 1'b0;
        recv_stall_pct = 0;

        while (board.pending_dirs.size() != 0)
            @(posedge i_clk);
        repeat (24) @(posedge i_clk);

        $display("run covered %0d requests over four handshake phases", requests_sent);
        $display("%0d results checked, %0d of them coincident, %0d mismatches",
                 board.checked, board.coincident_seen, board.errors);
        if (board.errors == 0)
            $display("[direction_angle_sector_core] OK");
        else
            $display("[direction_angle_sector_core] ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/das_pkg.sv
rtl/core/das_prep.sv
rtl/core/das_cell.sv
rtl/core/das_out.sv
rtl/core/direction_angle_sector_core.sv
tb/direction_angle_sector_core_tb.sv
